// ===== sv/sorted_occurrence_search_top_assert.svh =====
// Assertion macros used by the RTL of the sorted occurrence search block.
`ifndef SORTED_OCCURRENCE_SEARCH_TOP_ASSERT_SVH
`define SORTED_OCCURRENCE_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SOS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sos_pkg.sv =====
`default_nettype none
package sos_pkg;

    localparam int LEN_W  = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int POS_W  = 12;

    // Depth of the element store; the 10-bit index and 11-bit length fix it
    localparam int MAX_ELEMENTS = 1024;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_ARRAY_LENGTH = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_MID,
        ST_NBR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic probe;
        logic go_left;
        logic go_right;
        logic read_nbr;
        logic step_nbr;
        logic finish_hit;
        logic finish_miss;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic mid_gt;
        logic mid_lt;
        logic at_edge;
        logic nbr_diff;
        logic pass_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== sv/sos_ram.sv =====
`default_nettype none
module sos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/sos_ctrl.sv =====
`default_nettype none
module sos_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_op,
    output logic               s_ready,
    input  wire sos_pkg::stat_t stat,
    output sos_pkg::cmd_t      cmd
);

    sos_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sos_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sos_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == sos_pkg::OP_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = sos_pkg::ST_PROBE;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            sos_pkg::ST_PROBE: begin
                if (stat.in_range) begin
                    cmd.probe  = 1'b1;
                    state_next = sos_pkg::ST_MID;
                end else begin
                    cmd.finish_miss = 1'b1;
                    state_next = stat.pass_last ? sos_pkg::ST_DONE : sos_pkg::ST_PROBE;
                end
            end
            sos_pkg::ST_MID: begin
                priority if (stat.mid_gt) begin
                    cmd.go_left = 1'b1;
                    state_next  = sos_pkg::ST_PROBE;
                end else if (stat.mid_lt) begin
                    cmd.go_right = 1'b1;
                    state_next   = sos_pkg::ST_PROBE;
                end else if (stat.at_edge) begin
                    cmd.finish_hit = 1'b1;
                    state_next = stat.pass_last ? sos_pkg::ST_DONE : sos_pkg::ST_PROBE;
                end else begin
                    cmd.read_nbr = 1'b1;
                    state_next   = sos_pkg::ST_NBR;
                end
            end
            sos_pkg::ST_NBR: begin
                if (stat.nbr_diff) begin
                    cmd.finish_hit = 1'b1;
                    state_next = stat.pass_last ? sos_pkg::ST_DONE : sos_pkg::ST_PROBE;
                end else begin
                    cmd.step_nbr = 1'b1;
                    state_next   = sos_pkg::ST_PROBE;
                end
            end
            sos_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = sos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sos_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/sos_datapath.sv =====
`default_nettype none
module sos_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [sos_pkg::LEN_W-1:0]    array_length,
    input  wire logic [sos_pkg::IDX_W-1:0]    s_index,
    input  wire logic [sos_pkg::DATA_W-1:0]   s_value,
    input  wire sos_pkg::cmd_t                cmd,
    output sos_pkg::stat_t                    stat,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic [sos_pkg::IDX_W-1:0]         m_first,
    output logic [sos_pkg::IDX_W-1:0]         m_last,
    output logic [sos_pkg::LEN_W-1:0]         m_occ
);

    localparam int AW = $clog2(sos_pkg::MAX_ELEMENTS);

    logic [sos_pkg::DATA_W-1:0] key_reg;
    logic [sos_pkg::LEN_W-1:0]  n_reg;
    logic [sos_pkg::LEN_W-1:0]  low_reg;
    logic signed [sos_pkg::POS_W-1:0] high_reg;
    logic [sos_pkg::LEN_W-1:0]  mid_reg;
    logic                       pass_last_reg;
    logic                       first_ok_reg, last_ok_reg;
    logic [sos_pkg::LEN_W-1:0]  first_pos_reg, last_pos_reg;
    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [sos_pkg::IDX_W-1:0]  out_first_reg, out_last_reg;
    logic [sos_pkg::LEN_W-1:0]  out_occ_reg;

    logic [sos_pkg::LEN_W-1:0]  n_clamp;
    logic [sos_pkg::POS_W-1:0]  mid_sum;
    logic [sos_pkg::LEN_W-1:0]  mid_calc;
    logic [sos_pkg::LEN_W-1:0]  nbr_addr;
    logic [sos_pkg::LEN_W-1:0]  rd_addr;
    logic [sos_pkg::LEN_W-1:0]  mid_inc;
    logic signed [sos_pkg::POS_W-1:0] mid_dec;
    logic signed [sos_pkg::POS_W-1:0] full_high;
    logic [sos_pkg::DATA_W-1:0] rdata;
    logic                       wr_en;
    logic                       found;
    logic                       hit;

    // Clamp the configured length to the store depth
    always_comb begin
        if (32'(array_length) > 32'(sos_pkg::MAX_ELEMENTS)) begin
            n_clamp = sos_pkg::LEN_W'(sos_pkg::MAX_ELEMENTS);
        end else begin
            n_clamp = array_length;
        end
    end

    assign full_high = $signed({1'b0, n_clamp}) - sos_pkg::POS_W'(1);
    assign mid_sum   = {1'b0, low_reg} + {1'b0, high_reg[sos_pkg::LEN_W-1:0]};
    assign mid_calc  = mid_sum[sos_pkg::POS_W-1:1];
    assign mid_inc   = mid_reg + sos_pkg::LEN_W'(1);
    assign mid_dec   = $signed({1'b0, mid_reg}) - sos_pkg::POS_W'(1);
    assign nbr_addr  = pass_last_reg ? mid_inc : mid_dec[sos_pkg::LEN_W-1:0];
    assign rd_addr   = cmd.probe ? mid_calc : (cmd.read_nbr ? nbr_addr : mid_reg);
    assign wr_en     = cmd.load && (32'(s_index) < 32'(sos_pkg::MAX_ELEMENTS));

    sos_ram #(
        .WIDTH (sos_pkg::DATA_W),
        .DEPTH (sos_pkg::MAX_ELEMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (AW'(s_index)),
        .wdata (s_value),
        .raddr (AW'(rd_addr)),
        .rdata (rdata)
    );

    assign stat.in_range  = $signed({1'b0, low_reg}) <= high_reg;
    assign stat.mid_gt    = $signed(rdata) > $signed(key_reg);
    assign stat.mid_lt    = $signed(rdata) < $signed(key_reg);
    assign stat.at_edge   = pass_last_reg ? ({1'b0, mid_reg} + 12'd1 == {1'b0, n_reg})
                                          : (mid_reg == '0);
    assign stat.nbr_diff  = rdata != key_reg;
    assign stat.pass_last = pass_last_reg;
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign hit   = cmd.finish_hit;
    assign found = first_ok_reg && last_ok_reg;

    // Search registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg  <= s_value;
            n_reg    <= n_clamp;
            low_reg  <= '0;
            high_reg <= full_high;
        end
        if (cmd.probe) begin
            mid_reg <= mid_calc;
        end
        if (cmd.go_left || (cmd.step_nbr && !pass_last_reg)) begin
            high_reg <= mid_dec;
        end
        if (cmd.go_right || (cmd.step_nbr && pass_last_reg)) begin
            low_reg <= mid_inc;
        end
        if (cmd.finish_hit || cmd.finish_miss) begin
            if (!pass_last_reg) begin
                first_ok_reg  <= hit;
                first_pos_reg <= mid_reg;
                low_reg       <= '0;
                high_reg      <= $signed({1'b0, n_reg}) - sos_pkg::POS_W'(1);
            end else begin
                last_ok_reg  <= hit;
                last_pos_reg <= mid_reg;
            end
        end
        if (cmd.publish) begin
            out_found_reg <= found;
            out_first_reg <= found ? first_pos_reg[sos_pkg::IDX_W-1:0] : '0;
            out_last_reg  <= found ? last_pos_reg[sos_pkg::IDX_W-1:0] : '0;
            out_occ_reg   <= found ? (last_pos_reg - first_pos_reg + sos_pkg::LEN_W'(1)) : '0;
        end
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                pass_last_reg <= 1'b0;
            end else if ((cmd.finish_hit || cmd.finish_miss) && !pass_last_reg) begin
                pass_last_reg <= 1'b1;
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_found = out_found_reg;
    assign m_first = out_first_reg;
    assign m_last  = out_last_reg;
    assign m_occ   = out_occ_reg;

endmodule
`default_nettype wire

// ===== sv/sorted_occurrence_search_top.sv =====
// Load word: gives no result; a new word is taken every cycle while no query runs.
// Query word: one result after two binary searches, first for the first and
// then for the last occurrence, each probe and neighbour read going through
// the single registered read port. One query at a time; the result register
// lets the next word in while it waits.
// Reset (aresetn low, synchronous) clears the controller, output valid and length.
`default_nettype none
`include "sorted_occurrence_search_top_assert.svh"
module sorted_occurrence_search_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [9:0] index, [41:10] value, [47:42] zero
    input  wire logic        s_tuser,   // [0] op
    // Result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] first_index, [19:10] last_index,
                                        // [30:20] occurrences, [31] zero
    output logic             m_tuser,   // [0] found
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [sos_pkg::LEN_W-1:0] len_reg;
    logic                      cfg_wr;
    sos_pkg::cmd_t             cmd;
    sos_pkg::stat_t            stat;
    logic [sos_pkg::IDX_W-1:0] res_first, res_last;
    logic [sos_pkg::LEN_W-1:0] res_occ;

    // Register file: array_length at paddr 0-3; paddr 4-7 read zero and drop writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr && ({paddr[2], 2'b00} == sos_pkg::REG_ARRAY_LENGTH)) begin
            len_reg <= pwdata[sos_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        if ({paddr[2], 2'b00} == sos_pkg::REG_ARRAY_LENGTH) begin
            prdata = {21'd0, len_reg};
        end else begin
            prdata = '0;
        end
    end

    // Controller: sequences the two searches
    sos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_op    (s_tuser),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: element store, search bounds and result register
    sos_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .array_length (len_reg),
        .s_index      (s_tdata[9:0]),
        .s_value      (s_tdata[41:10]),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_found      (m_tuser),
        .m_first      (res_first),
        .m_last       (res_last),
        .m_occ        (res_occ)
    );

    assign m_tdata = {1'b0, res_occ, res_last, res_first};

    // A missed key carries all-zero indices and count
    `SOS_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 32'd0, "miss with nonzero fields")
    // A hit reports the count as the span of the two indices
    `SOS_ASSERT_IMPL(a_hit_count, aclk, aresetn, m_tvalid && m_tuser, res_occ == (sos_pkg::LEN_W'(res_last) - sos_pkg::LEN_W'(res_first) + 11'd1), "count does not match indices")
    // An accepted query holds off the next word
    `SOS_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == sos_pkg::OP_QUERY), !s_tready, "word taken during search")

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register map: register i sits at byte address 4*i; nothing lives at index 1.
    localparam logic [2:0] ADDR_ARRAY_LENGTH = 3'(4 * sos_pkg::REG_ARRAY_LENGTH);
    localparam logic [2:0] ADDR_SPARE        = 3'd4;

    localparam logic [sos_pkg::DATA_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [sos_pkg::DATA_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // Leave margin for a running query to finish before touching the register.
    localparam int SETTLE_CYCLES = 100;
    // Slowest legal run: every word with its longest search, plus settling
    // before each register write; the limit sits several times above that.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 160;

    typedef struct packed {
        logic                      found;
        logic [sos_pkg::IDX_W-1:0] first;
        logic [sos_pkg::IDX_W-1:0] last;
        logic [sos_pkg::LEN_W-1:0] occ;
    } hit_t;

    localparam hit_t NO_HIT = '0;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;
    typedef enum int {FILL_SORTED, FILL_SCRAMBLED, FILL_FLAT} fill_t;

    typedef struct {
        row_kind_t                  kind;
        logic [2:0]                 addr;
        logic [sos_pkg::IDX_W-1:0]  idx;
        logic [sos_pkg::DATA_W-1:0] val;
        bit                         typed;
        hit_t                       want;
    } row_t;

    // Clock, reset and block ports; every input is known from time zero.
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [47:0] s_tdata  = '0;    // [9:0] index, [41:10] value, [47:42] zero
    logic        s_tuser  = 1'b0;  // [0] op
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;          // [9:0] first_index, [19:10] last_index,
                                   // [30:20] occurrences, [31] zero
    wire         m_tuser;          // [0] found
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;

    // Shadow copy of the block: the element store and the length register.
    logic signed [sos_pkg::DATA_W-1:0] shadow_array [0:1023];
    logic [sos_pkg::LEN_W-1:0]         shadow_len = '0;

    // Contents meant for the current phase, used to aim query keys at real elements.
    logic [sos_pkg::DATA_W-1:0] layout [0:1023];

    hit_t pending_hits [$];
    row_t script [$];

    // Directed rows may carry a hand-written expectation alongside the word.
    bit   typed_on;
    hit_t typed_hit;

    bit send_burst;
    int errors;
    int n_words;
    int n_rand;
    int n_loads;
    int n_queries;
    int n_found;
    int n_cfg;
    int cycle_count;

    sorted_occurrence_search_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Give up on a hung block.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_hits.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Binary search over the shadow store, first or last edge; -1 when absent.
    function automatic int seek_bound(logic signed [sos_pkg::DATA_W-1:0] key, int n,
                                      bit want_last);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (shadow_array[mid] > key) begin
                hi = mid - 1;
            end else if (shadow_array[mid] < key) begin
                lo = mid + 1;
            end else if (!want_last) begin
                if (mid == 0 || shadow_array[mid - 1] != key)
                    return mid;
                hi = mid - 1;
            end else begin
                if (mid == n - 1 || shadow_array[mid + 1] != key)
                    return mid;
                lo = mid + 1;
            end
        end
        return -1;
    endfunction

    function automatic hit_t locate_key(logic signed [sos_pkg::DATA_W-1:0] key);
        int   n;
        int   first;
        int   last;
        hit_t h;
        // Lengths past the store are clamped to its size.
        n = (shadow_len > 11'd1024) ? 1024 : int'(shadow_len);
        first = seek_bound(key, n, 1'b0);
        last  = seek_bound(key, n, 1'b1);
        h = NO_HIT;
        if (first >= 0 && last >= 0) begin
            h.found = 1'b1;
            h.first = first[sos_pkg::IDX_W-1:0];
            h.last  = last[sos_pkg::IDX_W-1:0];
            // Wraps on a scrambled store where the last edge lies below the first.
            h.occ   = sos_pkg::LEN_W'(last - first + 1);
        end
        return h;
    endfunction

    function automatic hit_t mk_hit(int first, int last, int occ);
        hit_t h;
        h.found = 1'b1;
        h.first = sos_pkg::IDX_W'(first);
        h.last  = sos_pkg::IDX_W'(last);
        h.occ   = sos_pkg::LEN_W'(occ);
        return h;
    endfunction

    function automatic void add_row(row_kind_t kind, logic [2:0] addr, int idx,
                                    logic [sos_pkg::DATA_W-1:0] val, bit typed, hit_t want);
        row_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.idx   = sos_pkg::IDX_W'(idx);
        r.val   = val;
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endfunction

    // Aim most keys at loaded elements, some just beside them, some at the extremes or at random.
    function automatic logic [sos_pkg::DATA_W-1:0] pick_key(int span);
        int                         r;
        logic [sos_pkg::DATA_W-1:0] k;
        r = $urandom_range(0, 9);
        if (span == 0 || r == 9) begin
            k = $urandom;
        end else if (r == 7) begin
            k = KEY_MIN;
        end else if (r == 8) begin
            k = KEY_MAX;
        end else begin
            k = layout[$urandom_range(0, span - 1)];
            if (r == 6)
                k = ($urandom_range(0, 1) == 1) ? k + 32'd1 : k - 32'd1;
        end
        return k;
    endfunction

    // Offer one word after a random gap, none in a burst, and hold it until taken.
    // tvalid is left high on return so that a back-to-back word follows without a bubble.
    task automatic drive_word(input logic op, input logic [sos_pkg::IDX_W-1:0] idx,
                              input logic [sos_pkg::DATA_W-1:0] val, input bit typed,
                              input hit_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {6'b0, val, idx};
        typed_on  = typed;
        typed_hit = want;
        do @(posedge aclk); while (!s_tready);
        n_words++;
        n_rand++;
        @(negedge aclk);
    endtask

    // Drop tvalid, drain every outstanding result, then let a search still running
    // behind a load finish.
    task automatic hold_for_idle();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ARRAY_LENGTH)
            shadow_len = data[sos_pkg::LEN_W-1:0];
        n_cfg++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Junk in the upper bits of the write data must not reach the length.
    task automatic set_length(input int len);
        hold_for_idle();
        apb_write(ADDR_ARRAY_LENGTH, ($urandom & ~32'h7FF) | 32'(len));
    endtask

    task automatic ask_keys(input int count, input int span);
        int q;
        for (q = 0; q < count; q++) begin
            // Stray loads above the searched range must not disturb the answers.
            if (span < 1024 && $urandom_range(0, 9) == 0)
                drive_word(sos_pkg::OP_LOAD, sos_pkg::IDX_W'($urandom_range(span, 1023)),
                           $urandom, 1'b0, NO_HIT);
            drive_word(sos_pkg::OP_QUERY, sos_pkg::IDX_W'($urandom_range(0, 1023)),
                       pick_key(span), 1'b0, NO_HIT);
        end
    endtask

    // One phase: fill entries 0..len-1, set the length, then fire queries.
    task automatic run_phase(input int len, input bit big);
        fill_t                      fill;
        int                         spread;
        int unsigned                step_max;
        longint                     v;
        logic [sos_pkg::DATA_W-1:0] flat;
        bit                         backwards;
        int                         i;
        int                         k;
        int                         r;

        r = $urandom_range(0, 9);
        fill = big ? FILL_SORTED : (r < 7) ? FILL_SORTED : (r < 9) ? FILL_SCRAMBLED : FILL_FLAT;
        case (fill)
            FILL_SORTED: begin
                // Narrow steps give long runs of duplicates; wide steps cover the range.
                spread   = big ? 2 : $urandom_range(0, 2);
                step_max = (spread == 0) ? 2 : (spread == 1) ? 1000 : 32'hFFFF_FFFF / (len + 1);
                if (spread == 2 || $urandom_range(0, 3) == 0)
                    v = -64'sd2147483648;
                else
                    v = longint'($signed($urandom));
                for (i = 0; i < len; i++) begin
                    layout[i] = v[31:0];
                    if ($urandom_range(0, 2) != 0)
                        v += $urandom_range(0, step_max);
                    if (v > 64'sd2147483647)
                        v = 64'sd2147483647;
                end
                if (len > 0 && $urandom_range(0, 1) == 1)
                    layout[len - 1] = KEY_MAX;
            end
            FILL_SCRAMBLED: begin
                for (i = 0; i < len; i++)
                    layout[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : 32'($urandom_range(0, 15)) - 32'd8;
            end
            default: begin
                r = $urandom_range(0, 2);
                flat = (r == 0) ? KEY_MIN : (r == 1) ? KEY_MAX : $urandom;
                for (i = 0; i < len; i++)
                    layout[i] = flat;
            end
        endcase

        send_burst = big || $urandom_range(0, 3) == 0;
        backwards  = $urandom_range(0, 3) == 0;
        for (k = 0; k < len; k++) begin
            i = backwards ? len - 1 - k : k;
            if (!big && len < 1024 && $urandom_range(0, 7) == 0)
                drive_word(sos_pkg::OP_LOAD, sos_pkg::IDX_W'($urandom_range(len, 1023)),
                           $urandom, 1'b0, NO_HIT);
            drive_word(sos_pkg::OP_LOAD, sos_pkg::IDX_W'(i), layout[i], 1'b0, NO_HIT);
        end

        send_burst = !big && $urandom_range(0, 3) == 0;
        set_length(len);
        ask_keys(big ? 40 : $urandom_range(5, 30), len);
    endtask

    // Take accepted words into the shadow model and check result words, both at the
    // rising edge; the drive side only moves at the falling edge.
    always @(posedge aclk) begin
        hit_t want;
        hit_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.found = m_tuser;
                got.first = m_tdata[9:0];
                got.last  = m_tdata[19:10];
                got.occ   = m_tdata[30:20];
                if (got.found === 1'b1)
                    n_found++;
                if (pending_hits.size() == 0) begin
                    $display("%0t: result word with no query outstanding: found %0b first %0d last %0d count %0d",
                             $time, got.found, got.first, got.last, got.occ);
                    errors++;
                end else begin
                    want = pending_hits.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found: expected %0b, got %0b", $time, want.found,
                                 got.found);
                        errors++;
                    end
                    if (got.first !== want.first) begin
                        $display("%0t: first_index: expected %0d, got %0d", $time, want.first,
                                 got.first);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_index: expected %0d, got %0d", $time, want.last,
                                 got.last);
                        errors++;
                    end
                    if (got.occ !== want.occ) begin
                        $display("%0t: occurrences: expected %0d, got %0d", $time, want.occ,
                                 got.occ);
                        errors++;
                    end
                    if (m_tdata[31] !== 1'b0) begin
                        $display("%0t: result pad bit: expected 0, got %b", $time, m_tdata[31]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == sos_pkg::OP_LOAD) begin
                    shadow_array[s_tdata[9:0]] = s_tdata[41:10];
                    n_loads++;
                end else begin
                    pending_hits.push_back(typed_on ? typed_hit : locate_key(s_tdata[41:10]));
                    n_queries++;
                end
            end
        end
    end

    // Result side: stall a random number of cycles before each word, with
    // stretches of no stalling at all.
    initial begin
        int gap;
        bit recv_burst;
        recv_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 24) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int r;
        int len;
        int shorter;

        for (r = 0; r < 1024; r++) begin
            shadow_array[r] = '0;
            layout[r]       = '0;
        end

        // Directed table. Empty store after reset, then a small sorted store with
        // both extremes and runs of duplicates.
        add_row(ROW_QUERY, '0, 1023, KEY_MIN, 1'b1, NO_HIT);
        add_row(ROW_QUERY, '0, 0, KEY_MAX, 1'b1, NO_HIT);
        add_row(ROW_LOAD, '0, 0, KEY_MIN, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 1, 32'hFFFF_FFFB, 1'b0, NO_HIT);    // -5
        add_row(ROW_LOAD, '0, 2, 32'hFFFF_FFFB, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 3, 32'h0000_0000, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 4, 32'h0000_0007, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 5, 32'h0000_0007, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 6, 32'h0000_0007, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 7, KEY_MAX, 1'b0, NO_HIT);
        add_row(ROW_LOAD, '0, 1023, 32'h5A5A_A5A5, 1'b0, NO_HIT);  // top address, never read
        add_row(ROW_CFG, ADDR_ARRAY_LENGTH, 0, 32'd8, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, KEY_MIN, 1'b1, mk_hit(0, 0, 1));
        add_row(ROW_QUERY, '0, 1023, KEY_MAX, 1'b1, mk_hit(7, 7, 1));
        add_row(ROW_QUERY, '0, 5, 32'h0000_0007, 1'b1, mk_hit(4, 6, 3));
        add_row(ROW_QUERY, '0, 5, 32'hFFFF_FFFB, 1'b1, mk_hit(1, 2, 2));
        add_row(ROW_QUERY, '0, 0, 32'h0000_0003, 1'b1, NO_HIT);
        add_row(ROW_QUERY, '0, 0, 32'h7FFF_FFFE, 1'b1, NO_HIT);
        // A write to an empty slot of the map leaves the length alone.
        add_row(ROW_CFG, ADDR_SPARE, 0, 32'd1, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, 32'h0000_0000, 1'b1, mk_hit(3, 3, 1));
        add_row(ROW_CFG, ADDR_ARRAY_LENGTH, 0, 32'd1, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, KEY_MIN, 1'b1, mk_hit(0, 0, 1));
        add_row(ROW_QUERY, '0, 0, 32'h0000_0007, 1'b1, NO_HIT);
        // Break the ordering and let the searches run as they will.
        add_row(ROW_LOAD, '0, 2, 32'hFFFF_FF9C, 1'b0, NO_HIT);    // -100
        add_row(ROW_CFG, ADDR_ARRAY_LENGTH, 0, 32'd8, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, 32'hFFFF_FFFB, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, 32'hFFFF_FF9C, 1'b0, NO_HIT);
        add_row(ROW_QUERY, '0, 0, 32'h0000_0007, 1'b0, NO_HIT);

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            case (script[i].kind)
                ROW_CFG: begin
                    hold_for_idle();
                    apb_write(script[i].addr, script[i].val);
                end
                ROW_LOAD:
                    drive_word(sos_pkg::OP_LOAD, script[i].idx, script[i].val, 1'b0, NO_HIT);
                default:
                    drive_word(sos_pkg::OP_QUERY, script[i].idx, script[i].val,
                               script[i].typed, script[i].want);
            endcase
        end

        // Fill the whole store once, then search it at full size and with lengths
        // past the store, which clamp to it.
        run_phase(1024, 1'b1);
        set_length(2047);
        ask_keys(20, 1024);
        set_length(1025);
        ask_keys(10, 1024);

        // Random phases: mostly short arrays, some empty, a few of a few hundred.
        n_rand = 0;
        while (n_rand < RANDOM_WORDS) begin
            r = $urandom_range(0, 9);
            len = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2 :
                  (r == 3) ? $urandom_range(100, 300) : $urandom_range(3, 40);
            run_phase(len, 1'b0);
            // Sometimes shrink the window over the same contents.
            if ($urandom_range(0, 2) == 0) begin
                shorter = $urandom_range(0, len);
                set_length(shorter);
                ask_keys($urandom_range(3, 15), shorter);
            end
        end

        hold_for_idle();
        if (pending_hits.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_hits.size());
            errors++;
        end

        $display("Sent %0d words: %0d loads and %0d queries (%0d found), %0d register writes.",
                 n_words, n_loads, n_queries, n_found, n_cfg);
        $display("Lengths 0 to 1024 and beyond; sorted, duplicate-heavy, flat and unsorted stores.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
